// ===== design/pltbl_pkg.sv =====
// ----------------------------------------------------------------------------
// pltbl_pkg
// Shared types and constants for the piecewise-linear table interpolator:
// controller states, datapath command and status bundles, result codes.
// ----------------------------------------------------------------------------
package pltbl_pkg;

    // default configuration
    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int DEFAULT_VALUE_WIDTH = 32;

    // fixed field widths
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int STATUS_W = 2;

    // weight format: Q1.16 fraction saturated to [0, 1.0]
    localparam int FRAC_BITS = 16;
    localparam int WEIGHT_BITS = FRAC_BITS + 1;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam int STEP_W = $clog2(WEIGHT_BITS + 1);

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INTERIOR = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLAMP_LOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLAMP_HIGH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_LO,
        S_CHK_HI,
        S_SEARCH,
        S_FETCH0,
        S_FETCH1,
        S_DIFF,
        S_PREP,
        S_DIV,
        S_MUL,
        S_FIN,
        S_DONE
    } state_t;

    // table read address select
    typedef enum logic [2:0] {
        ADDR_ZERO,
        ADDR_LAST,
        ADDR_MID0,
        ADDR_MID,
        ADDR_LO,
        ADDR_LO_NEXT
    } addr_sel_t;

    // result capture select
    typedef enum logic [2:0] {
        RES_NONE,
        RES_EMPTY,
        RES_LOW,
        RES_HIGH,
        RES_INTERIOR
    } res_sel_t;

    // controller to datapath
    typedef struct packed {
        logic      load_wr;
        logic      query_take;
        addr_sel_t addr_sel;
        logic      search_init;
        logic      search_step;
        logic      lo_latch;
        logic      p0_latch;
        logic      diff_latch;
        logic      prep;
        logic      div_step;
        logic      mul_step;
        res_sel_t  res_sel;
        logic      out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic n_zero;
        logic n_one;
        logic x_le;
        logic x_ge;
        logic search_done;
        logic w_forced;
    } dp_status_t;

endpackage

// ===== design/piecewise_linear_table_interp_core.sv =====
// Load items are taken one per cycle while the controller is idle; they give no result.
// Query: an empty table goes straight to done; otherwise x is checked against both end
// points for clamping, and an interior point runs the one-step-per-cycle search, the
// 16-step divider (skipped when the weight saturates) and the 17-step shift-add
// multiplier. The next item can be taken in the cycle in which result_valid rises, later
// while an earlier result stalls. Reset clears control and point_count, not the tables.
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_core
// Piecewise-linear lookup over a breakpoint table in signed Q16.16, with
// clamping at both ends and a binary search for the enclosing interval.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_core #(
    parameter int TABLE_DEPTH = pltbl_pkg::DEFAULT_TABLE_DEPTH,
    parameter int VALUE_WIDTH = pltbl_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [pltbl_pkg::COUNT_W-1:0]      cfg_wr_data,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic                               operation,
    input  logic [pltbl_pkg::INDEX_W-1:0]      entry_index,
    input  logic signed [VALUE_WIDTH-1:0]      x_value,
    input  logic signed [VALUE_WIDTH-1:0]      f_value,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [VALUE_WIDTH-1:0]      f_result,
    output logic [pltbl_pkg::STATUS_W-1:0]     status
);

    pltbl_pkg::dp_cmd_t    cmd;
    pltbl_pkg::dp_status_t dp_status;

    // sequencing and handshakes
    pltbl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .operation    (operation),
        .result_stall (result_stall),
        .dp_status    (dp_status),
        .cmd          (cmd),
        .item_stall   (item_stall),
        .result_valid (result_valid)
    );

    // tables and arithmetic
    pltbl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .entry_index (entry_index),
        .x_value     (x_value),
        .f_value     (f_value),
        .cmd         (cmd),
        .status_out  (dp_status),
        .f_result    (f_result),
        .status      (status)
    );

endmodule

// ===== design/pltbl_dp.sv =====
// ----------------------------------------------------------------------------
// pltbl_dp
// Datapath: breakpoint memories, count register, binary search registers,
// restoring divider for the weight, shift-add multiplier and result regs.
// ----------------------------------------------------------------------------
module pltbl_dp #(
    parameter int TABLE_DEPTH = pltbl_pkg::DEFAULT_TABLE_DEPTH,
    parameter int VALUE_WIDTH = pltbl_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [pltbl_pkg::COUNT_W-1:0]      cfg_wr_data,
    input  logic [pltbl_pkg::INDEX_W-1:0]      entry_index,
    input  logic signed [VALUE_WIDTH-1:0]      x_value,
    input  logic signed [VALUE_WIDTH-1:0]      f_value,
    input  pltbl_pkg::dp_cmd_t                 cmd,
    output pltbl_pkg::dp_status_t              status_out,
    output logic signed [VALUE_WIDTH-1:0]      f_result,
    output logic [pltbl_pkg::STATUS_W-1:0]     status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = VALUE_WIDTH + 1;
    localparam int PW = DW + pltbl_pkg::WEIGHT_BITS;
    localparam int WB = pltbl_pkg::WEIGHT_BITS;
    localparam int VW = VALUE_WIDTH;

    // breakpoint storage
    logic [VW-1:0] abs_mem [TABLE_DEPTH];
    logic [VW-1:0] ord_mem [TABLE_DEPTH];

    logic [pltbl_pkg::COUNT_W-1:0] count_reg;
    logic signed [VW-1:0] x_reg;
    logic signed [VW-1:0] rd_x_reg;
    logic signed [VW-1:0] rd_f_reg;
    logic signed [VW-1:0] x0_reg;
    logic signed [VW-1:0] f0_reg;
    logic [AW-1:0] cpos_reg;
    logic [CW-1:0] len_reg;
    logic [AW-1:0] mid_reg;
    logic [AW-1:0] lo_reg;
    logic [DW-1:0] a_mag_reg;
    logic [DW-1:0] d_mag_reg;
    logic          w_zero_reg;
    logic [DW-1:0] df_mag_reg;
    logic          df_neg_reg;
    logic [DW-1:0] rem_reg;
    logic [WB-1:0] w_reg;
    logic [PW-1:0] acc_reg;
    logic signed [VW-1:0] res_reg;
    logic [pltbl_pkg::STATUS_W-1:0] res_st_reg;
    logic signed [VW-1:0] f_result_reg;
    logic [pltbl_pkg::STATUS_W-1:0] status_reg;

    logic [CW-1:0] n;
    logic [AW-1:0] wr_addr;
    logic          idx_ok;
    logic [AW-1:0] rd_addr;
    logic          gt;
    logic [CW-1:0] len_half;
    logic [CW-1:0] len_new;
    logic [AW-1:0] cpos_new;
    logic [AW-1:0] mid_new;
    logic [AW-1:0] lo_fix;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
    logic [DW-1:0] df;
    logic [DW:0]   rem2;
    logic          rem_ge;
    logic [DW:0]   f0_ext;
    logic [DW:0]   delta;
    logic [DW:0]   sum;

    // points in use, saturated to the table depth
    assign n = (32'(count_reg) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(count_reg);

    assign wr_addr = AW'(entry_index);
    assign idx_ok = (32'(entry_index) < TABLE_DEPTH);

    // one binary search step on the entry read last cycle
    assign gt = (rd_x_reg > x_reg);
    assign len_half = len_reg >> 1;
    assign len_new = gt ? len_half : (len_reg - len_half);
    assign cpos_new = gt ? cpos_reg : mid_reg;
    assign mid_new = AW'(CW'(cpos_new) + (len_new >> 1));

    // interval start, pulled back when the search lands on the last point
    assign lo_fix = ((CW'(cpos_reg) + CW'(1)) >= n) ? AW'(n - CW'(2)) : cpos_reg;

    // read address select
    always_comb
    begin
        unique case (cmd.addr_sel)
            pltbl_pkg::ADDR_ZERO:    rd_addr = '0;
            pltbl_pkg::ADDR_LAST:    rd_addr = AW'(n - CW'(1));
            pltbl_pkg::ADDR_MID0:    rd_addr = AW'(n >> 1);
            pltbl_pkg::ADDR_MID:     rd_addr = mid_new;
            pltbl_pkg::ADDR_LO:      rd_addr = lo_fix;
            pltbl_pkg::ADDR_LO_NEXT: rd_addr = lo_reg + AW'(1);
            default:                 rd_addr = '0;
        endcase
    end

    // abscissa memory
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && idx_ok)
        begin
            abs_mem[wr_addr] <= x_value;
        end
        rd_x_reg <= abs_mem[rd_addr];
    end

    // ordinate memory
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && idx_ok)
        begin
            ord_mem[wr_addr] <= f_value;
        end
        rd_f_reg <= ord_mem[rd_addr];
    end

    // point count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            count_reg <= cfg_wr_data;
        end
    end

    // differences for the weight and the slope
    assign num = {x_reg[VW-1], x_reg} - {x0_reg[VW-1], x0_reg};
    assign den = {rd_x_reg[VW-1], rd_x_reg} - {x0_reg[VW-1], x0_reg};
    assign df = {rd_f_reg[VW-1], rd_f_reg} - {f0_reg[VW-1], f0_reg};

    // restoring divider step
    assign rem2 = {rem_reg, 1'b0};
    assign rem_ge = (rem2 >= {1'b0, d_mag_reg});

    // truncated delta applied to the left ordinate
    assign f0_ext = {{2{f0_reg[VW-1]}}, f0_reg};
    assign delta = acc_reg[PW-1:pltbl_pkg::FRAC_BITS];
    assign sum = df_neg_reg ? (f0_ext - delta) : (f0_ext + delta);

    // query, search and arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.query_take)
        begin
            x_reg <= x_value;
        end
        if (cmd.search_init)
        begin
            cpos_reg <= '0;
            len_reg <= n;
            mid_reg <= AW'(n >> 1);
        end
        else if (cmd.search_step)
        begin
            cpos_reg <= cpos_new;
            len_reg <= len_new;
            mid_reg <= mid_new;
        end
        if (cmd.lo_latch)
        begin
            lo_reg <= lo_fix;
        end
        if (cmd.p0_latch)
        begin
            x0_reg <= rd_x_reg;
            f0_reg <= rd_f_reg;
        end
        if (cmd.diff_latch)
        begin
            a_mag_reg <= num[DW-1] ? (-num) : num;
            d_mag_reg <= den[DW-1] ? (-den) : den;
            w_zero_reg <= (den == '0) || (num[DW-1] != den[DW-1]);
            df_mag_reg <= df[DW-1] ? (-df) : df;
            df_neg_reg <= df[DW-1];
        end
        if (cmd.prep)
        begin
            rem_reg <= a_mag_reg;
            acc_reg <= '0;
            if (w_zero_reg)
            begin
                w_reg <= '0;
            end
            else if (a_mag_reg >= d_mag_reg)
            begin
                w_reg <= pltbl_pkg::WEIGHT_ONE;
            end
            else
            begin
                w_reg <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? DW'(rem2 - {1'b0, d_mag_reg}) : DW'(rem2);
            w_reg <= {w_reg[WB-2:0], rem_ge};
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= {acc_reg[PW-2:0], 1'b0} + (w_reg[WB-1] ? PW'(df_mag_reg) : PW'(0));
            w_reg <= {w_reg[WB-2:0], 1'b0};
        end
    end

    // result capture and output register
    always_ff @(posedge clk)
    begin
        unique case (cmd.res_sel)
            pltbl_pkg::RES_EMPTY:
            begin
                res_reg <= '0;
                res_st_reg <= pltbl_pkg::ST_EMPTY;
            end
            pltbl_pkg::RES_LOW:
            begin
                res_reg <= rd_f_reg;
                res_st_reg <= pltbl_pkg::ST_CLAMP_LOW;
            end
            pltbl_pkg::RES_HIGH:
            begin
                res_reg <= rd_f_reg;
                res_st_reg <= pltbl_pkg::ST_CLAMP_HIGH;
            end
            pltbl_pkg::RES_INTERIOR:
            begin
                res_reg <= sum[VW-1:0];
                res_st_reg <= pltbl_pkg::ST_INTERIOR;
            end
            default:
            begin
                res_reg <= res_reg;
                res_st_reg <= res_st_reg;
            end
        endcase
        if (cmd.out_load)
        begin
            f_result_reg <= res_reg;
            status_reg <= res_st_reg;
        end
    end

    assign f_result = f_result_reg;
    assign status = status_reg;

    // status to the controller
    assign status_out.n_zero = (n == '0);
    assign status_out.n_one = (n == CW'(1));
    assign status_out.x_le = (x_reg <= rd_x_reg);
    assign status_out.x_ge = (x_reg >= rd_x_reg);
    assign status_out.search_done = (len_new <= CW'(1));
    assign status_out.w_forced = w_zero_reg || (a_mag_reg >= d_mag_reg);

    // search only runs while more than one candidate is left
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.search_step |-> (len_reg > CW'(1)))
        else $error("search step with a single candidate");

    // probed entry lies inside the points in use
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.search_step |-> (CW'(mid_reg) < n))
        else $error("search probe beyond points in use");

    // right end of the interval stays inside the points in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.addr_sel == pltbl_pkg::ADDR_LO_NEXT) |-> ((CW'(lo_reg) + CW'(1)) < n))
        else $error("interval end beyond points in use");

endmodule

// ===== design/pltbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pltbl_ctrl
// Controller: sequences clamp checks, binary search, weight division and
// multiply, and owns the input and result handshakes.
// ----------------------------------------------------------------------------
module pltbl_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  logic                    operation,
    input  logic                    result_stall,
    input  pltbl_pkg::dp_status_t   dp_status,
    output pltbl_pkg::dp_cmd_t      cmd,
    output logic                    item_stall,
    output logic                    result_valid
);

    pltbl_pkg::state_t state_reg;
    pltbl_pkg::state_t state_next;
    logic [pltbl_pkg::STEP_W-1:0] cnt_reg;
    logic [pltbl_pkg::STEP_W-1:0] cnt_next;
    logic result_valid_reg;
    logic result_valid_next;
    logic out_free;

    assign out_free = !result_valid_reg || !result_stall;

    // state and step counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pltbl_pkg::S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            pltbl_pkg::S_IDLE:
            begin
                if (item_valid && (operation == pltbl_pkg::OP_QUERY))
                begin
                    state_next = dp_status.n_zero ? pltbl_pkg::S_DONE : pltbl_pkg::S_CHK_LO;
                end
            end
            pltbl_pkg::S_CHK_LO:
            begin
                state_next = dp_status.x_le ? pltbl_pkg::S_DONE : pltbl_pkg::S_CHK_HI;
            end
            pltbl_pkg::S_CHK_HI:
            begin
                state_next = (dp_status.x_ge || dp_status.n_one) ?
                             pltbl_pkg::S_DONE : pltbl_pkg::S_SEARCH;
            end
            pltbl_pkg::S_SEARCH:
            begin
                if (dp_status.search_done)
                begin
                    state_next = pltbl_pkg::S_FETCH0;
                end
            end
            pltbl_pkg::S_FETCH0:
            begin
                state_next = pltbl_pkg::S_FETCH1;
            end
            pltbl_pkg::S_FETCH1:
            begin
                state_next = pltbl_pkg::S_DIFF;
            end
            pltbl_pkg::S_DIFF:
            begin
                state_next = pltbl_pkg::S_PREP;
            end
            pltbl_pkg::S_PREP:
            begin
                cnt_next = '0;
                state_next = dp_status.w_forced ? pltbl_pkg::S_MUL : pltbl_pkg::S_DIV;
            end
            pltbl_pkg::S_DIV:
            begin
                if (cnt_reg == pltbl_pkg::STEP_W'(pltbl_pkg::FRAC_BITS - 1))
                begin
                    cnt_next = '0;
                    state_next = pltbl_pkg::S_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + pltbl_pkg::STEP_W'(1);
                end
            end
            pltbl_pkg::S_MUL:
            begin
                if (cnt_reg == pltbl_pkg::STEP_W'(pltbl_pkg::WEIGHT_BITS - 1))
                begin
                    cnt_next = '0;
                    state_next = pltbl_pkg::S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + pltbl_pkg::STEP_W'(1);
                end
            end
            pltbl_pkg::S_FIN:
            begin
                state_next = pltbl_pkg::S_DONE;
            end
            pltbl_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = pltbl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pltbl_pkg::S_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd = '0;
        cmd.addr_sel = pltbl_pkg::ADDR_ZERO;
        cmd.res_sel = pltbl_pkg::RES_NONE;
        item_stall = 1'b1;
        unique case (state_reg)
            pltbl_pkg::S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    if (operation == pltbl_pkg::OP_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.query_take = 1'b1;
                        if (dp_status.n_zero)
                        begin
                            cmd.res_sel = pltbl_pkg::RES_EMPTY;
                        end
                    end
                end
            end
            pltbl_pkg::S_CHK_LO:
            begin
                cmd.addr_sel = pltbl_pkg::ADDR_LAST;
                if (dp_status.x_le)
                begin
                    cmd.res_sel = pltbl_pkg::RES_LOW;
                end
            end
            pltbl_pkg::S_CHK_HI:
            begin
                cmd.addr_sel = pltbl_pkg::ADDR_MID0;
                cmd.search_init = 1'b1;
                if (dp_status.x_ge || dp_status.n_one)
                begin
                    cmd.res_sel = pltbl_pkg::RES_HIGH;
                end
            end
            pltbl_pkg::S_SEARCH:
            begin
                cmd.addr_sel = pltbl_pkg::ADDR_MID;
                cmd.search_step = 1'b1;
            end
            pltbl_pkg::S_FETCH0:
            begin
                cmd.addr_sel = pltbl_pkg::ADDR_LO;
                cmd.lo_latch = 1'b1;
            end
            pltbl_pkg::S_FETCH1:
            begin
                cmd.addr_sel = pltbl_pkg::ADDR_LO_NEXT;
                cmd.p0_latch = 1'b1;
            end
            pltbl_pkg::S_DIFF:
            begin
                cmd.diff_latch = 1'b1;
            end
            pltbl_pkg::S_PREP:
            begin
                cmd.prep = 1'b1;
            end
            pltbl_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            pltbl_pkg::S_MUL:
            begin
                cmd.mul_step = 1'b1;
            end
            pltbl_pkg::S_FIN:
            begin
                cmd.res_sel = pltbl_pkg::RES_INTERIOR;
            end
            pltbl_pkg::S_DONE:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        priority if (cmd.out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

    // a query transfer always occupies the controller for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && (operation == pltbl_pkg::OP_QUERY)) |=> item_stall)
        else $error("query not held busy after transfer");

    // a finished result leaves the done state once the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == pltbl_pkg::S_DONE) && !result_valid_reg) |=>
        ((state_reg == pltbl_pkg::S_IDLE) && result_valid_reg))
        else $error("result stuck in done state");

    // a stalled result stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |=> result_valid_reg)
        else $error("result dropped while stalled");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for piecewise_linear_table_interp_core. It walks a short
// directed list of loads, queries and point_count writes. It then runs random phases
// that set point_count, mostly after loading a breakpoint set, and send a burst of
// queries, each checked against a local fixed-point interpolator or a typed answer.
// ----------------------------------------------------------------------------
module testbench;

    localparam int VW = pltbl_pkg::DEFAULT_VALUE_WIDTH;
    localparam int DEPTH = pltbl_pkg::DEFAULT_TABLE_DEPTH;
    localparam longint WEIGHT_SCALE = longint'(1) << pltbl_pkg::FRAC_BITS;
    localparam logic signed [VW-1:0] MIN_V = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] MAX_V = {1'b0, {(VW-1){1'b1}}};
    localparam int ITEM_TARGET = 1600;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic signed [VW-1:0]           value;
        logic [pltbl_pkg::STATUS_W-1:0] code;
    } answer_t;

    typedef enum {ROW_LOAD, ROW_QUERY, ROW_COUNT} row_kind_t;

    typedef struct {
        row_kind_t                     kind;
        logic [pltbl_pkg::INDEX_W-1:0] index;
        logic signed [VW-1:0]          x;
        logic signed [VW-1:0]          f;
        logic [pltbl_pkg::COUNT_W-1:0] count;
        bit                            typed;
        answer_t                       ans;
    } row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [pltbl_pkg::COUNT_W-1:0]  cfg_wr_data;
    logic                           item_valid;
    logic                           item_stall;
    logic                           operation;
    logic [pltbl_pkg::INDEX_W-1:0]  entry_index;
    logic signed [VW-1:0]           x_value;
    logic signed [VW-1:0]           f_value;
    logic                           result_valid;
    logic                           result_stall;
    logic signed [VW-1:0]           f_result;
    logic [pltbl_pkg::STATUS_W-1:0] status;

    // local copy of the breakpoint store and the count register
    logic signed [VW-1:0]          abscissa_mem [DEPTH];
    logic signed [VW-1:0]          ordinate_mem [DEPTH];
    logic [pltbl_pkg::COUNT_W-1:0] point_count_cfg;

    answer_t expected_answers [$];
    row_t    directed_rows [$];
    answer_t want;

    int  mismatches;
    int  items_sent;
    int  loads_sent;
    int  queries_sent;
    int  count_writes;
    int  status_seen [4];
    int  hold_left;
    int  cycle_count;
    bit  calm;

    piecewise_linear_table_interp_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operation    (operation),
        .entry_index  (entry_index),
        .x_value      (x_value),
        .f_value      (f_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .f_result     (f_result),
        .status       (status)
    );

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_answers.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // uniform value in [lo, hi]
    function automatic longint rand_between(longint lo, longint hi);
        bit [63:0] raw;
        raw = {$urandom, $urandom};
        return lo + longint'(raw % 64'(hi - lo + 1));
    endfunction

    // breakpoints in use, saturated at the store depth
    function automatic int live_points();
        return (point_count_cfg > DEPTH) ? DEPTH : int'(point_count_cfg);
    endfunction

    // interpolated value and status for a query point
    function automatic answer_t interpolate_point(logic signed [VW-1:0] x);
        answer_t ans;
        int      live;
        int      lo_pos;
        int      len;
        int      mid;
        longint  x0;
        longint  x1;
        longint  f0;
        longint  f1;
        longint  den;
        longint  w;
        live = live_points();
        if (live == 0)
        begin
            ans.value = '0;
            ans.code = pltbl_pkg::ST_EMPTY;
        end
        else if (x <= abscissa_mem[0])
        begin
            ans.value = ordinate_mem[0];
            ans.code = pltbl_pkg::ST_CLAMP_LOW;
        end
        else if (x >= abscissa_mem[live-1] || live == 1)
        begin
            ans.value = ordinate_mem[live-1];
            ans.code = pltbl_pkg::ST_CLAMP_HIGH;
        end
        else
        begin
            // binary search for the last entry not above x
            lo_pos = 0;
            len = live;
            while (len > 1)
            begin
                mid = lo_pos + len / 2;
                if (abscissa_mem[mid] > x)
                    len = mid - lo_pos;
                else
                begin
                    len -= mid - lo_pos;
                    lo_pos = mid;
                end
            end
            if (lo_pos + 1 >= live)
                lo_pos = live - 2;
            x0 = abscissa_mem[lo_pos];
            x1 = abscissa_mem[lo_pos+1];
            f0 = ordinate_mem[lo_pos];
            f1 = ordinate_mem[lo_pos+1];
            // q1.16 weight, truncated and saturated to [0, 1]
            den = x1 - x0;
            w = (den != 0) ? ((longint'(x) - x0) * WEIGHT_SCALE) / den : 0;
            if (w < 0)
                w = 0;
            if (w > WEIGHT_SCALE)
                w = WEIGHT_SCALE;
            ans.value = VW'(f0 + ((f1 - f0) * w) / WEIGHT_SCALE);
            ans.code = pltbl_pkg::ST_INTERIOR;
        end
        return ans;
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(input logic op, input logic [pltbl_pkg::INDEX_W-1:0] idx,
                             input logic signed [VW-1:0] x,
                             input logic signed [VW-1:0] f,
                             input bit typed, input answer_t typed_ans);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 33)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        operation <= op;
        entry_index <= idx;
        x_value <= x;
        f_value <= f;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        // accepted at this edge
        items_sent++;
        if (op == pltbl_pkg::OP_LOAD)
        begin
            abscissa_mem[idx] = x;
            ordinate_mem[idx] = f;
            loads_sent++;
        end
        else
        begin
            expected_answers.push_back(typed ? typed_ans : interpolate_point(x));
            queries_sent++;
        end
    endtask

    // stop sending, collect every result, let a trailing load finish
    task automatic quiesce();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_point_count(input logic [pltbl_pkg::COUNT_W-1:0] value);
        quiesce();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        point_count_cfg = value;
        count_writes++;
    endtask

    task automatic add_row(input row_kind_t kind, input int idx,
                           input logic signed [VW-1:0] x,
                           input logic signed [VW-1:0] f, input int count,
                           input bit typed, input logic signed [VW-1:0] value,
                           input logic [pltbl_pkg::STATUS_W-1:0] code);
        row_t row;
        row.kind = kind;
        row.index = pltbl_pkg::INDEX_W'(idx);
        row.x = x;
        row.f = f;
        row.count = pltbl_pkg::COUNT_W'(count);
        row.typed = typed;
        row.ans.value = value;
        row.ans.code = code;
        directed_rows.push_back(row);
    endtask

    // sorted breakpoints into entries 0..n-1, optionally with some disorder
    task automatic load_breakpoints(input int n, input bit scramble);
        longint step_max;
        longint pos;
        logic signed [VW-1:0] x;
        int r;
        step_max = longint'(1) << $urandom_range(30 - $clog2(n), 0);
        pos = rand_between(MIN_V, longint'(MAX_V) - n * step_max);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(9);
            // a skipped step leaves a zero-width interval
            if (i > 0 && !(scramble && r == 1))
                pos += rand_between(1, step_max);
            if (scramble && r == 0)
                x = $urandom;
            else
                x = VW'(pos);
            send_item(pltbl_pkg::OP_LOAD, pltbl_pkg::INDEX_W'(i), x, $urandom, 1'b0, '0);
        end
    endtask

    // query point: mostly inside the table span, sometimes on or past its ends
    function automatic logic signed [VW-1:0] pick_query_x(input int live);
        longint a;
        longint b;
        longint lo;
        longint hi;
        if (live == 0)
            return $urandom;
        a = abscissa_mem[0];
        b = abscissa_mem[live-1];
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        case ($urandom_range(9))
            0: return abscissa_mem[$urandom_range(live - 1)];
            1: return VW'(rand_between(MIN_V, a));
            2: return VW'(rand_between(b, MAX_V));
            3: return $urandom;
            4: return $urandom_range(1) ? MIN_V : MAX_V;
            default: return VW'(rand_between(lo, hi));
        endcase
    endfunction

    // queries with a few stray loads mixed in
    task automatic query_burst(input int n);
        int live;
        int r;
        live = live_points();
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 3)
                send_item(pltbl_pkg::OP_LOAD, pltbl_pkg::INDEX_W'($urandom), $urandom,
                          $urandom, 1'b0, '0);
            else if (r < 5 && live > 0)
                send_item(pltbl_pkg::OP_LOAD, pltbl_pkg::INDEX_W'($urandom_range(live - 1)),
                          $urandom, $urandom, 1'b0, '0);
            else
                send_item(pltbl_pkg::OP_QUERY, pltbl_pkg::INDEX_W'($urandom),
                          pick_query_x(live), $urandom, 1'b0, '0);
        end
    endtask

    // result side stall: random, held off on request, or free running
    initial
    begin : result_sink
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else if (!calm && $urandom_range(99) < 33)
                result_stall <= 1'b1;
            else
                result_stall <= 1'b0;
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        if (result_valid && !result_stall)
        begin
            if (expected_answers.size() == 0)
            begin
                mismatches++;
                $display("%0t: result transfer with nothing expected: f_result %0d status %0d",
                         $time, f_result, status);
            end
            else
            begin
                want = expected_answers.pop_front();
                status_seen[want.code]++;
                if (f_result !== want.value)
                begin
                    mismatches++;
                    $display("%0t: f_result expected %0d, actual %0d", $time,
                             want.value, f_result);
                end
                if (status !== want.code)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d, actual %0d", $time,
                             want.code, status);
                end
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int phase;
        int count;
        int reload;
        int r;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        item_valid = 1'b0;
        operation = pltbl_pkg::OP_LOAD;
        entry_index = '0;
        x_value = '0;
        f_value = '0;
        point_count_cfg = '0;
        calm = 1'b0;
        hold_left = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, single point, extremes, unsorted entries
        add_row(ROW_QUERY, 0, 0, 0, 0, 1, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_QUERY, 0, MAX_V, MIN_V, 0, 1, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_LOAD, 0, MIN_V, MAX_V, 0, 0, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_COUNT, 0, 0, 0, 1, 0, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_QUERY, 0, MIN_V, 0, 0, 1, MAX_V, pltbl_pkg::ST_CLAMP_LOW);
        add_row(ROW_QUERY, 0, MAX_V, 0, 0, 1, MAX_V, pltbl_pkg::ST_CLAMP_HIGH);
        add_row(ROW_LOAD, 1, 0, 0, 0, 0, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_LOAD, 2, MAX_V, MIN_V, 0, 0, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_COUNT, 0, 0, 0, 3, 0, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_QUERY, 0, 0, 0, 0, 1, 0, pltbl_pkg::ST_INTERIOR);
        add_row(ROW_QUERY, 0, MAX_V, 0, 0, 1, MIN_V, pltbl_pkg::ST_CLAMP_HIGH);
        add_row(ROW_QUERY, 0, -1, 0, 0, 0, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_QUERY, 0, 32'sh4000_0000, 0, 0, 0, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_QUERY, 0, MIN_V + 1, 0, 0, 0, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_QUERY, 0, MAX_V - 1, 0, 0, 0, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_LOAD, 3, 32'sh0001_0000, MAX_V, 0, 0, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_LOAD, 2, 32'sh0002_0000, MIN_V, 0, 0, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_COUNT, 0, 0, 0, 4, 0, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_QUERY, 0, 32'sh0000_8000, 0, 0, 0, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_QUERY, 0, 32'sh0000_c000, 0, 0, 0, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_QUERY, 0, 32'sh0000_ffff, 0, 0, 0, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_COUNT, 0, 0, 0, 0, 0, 0, pltbl_pkg::ST_EMPTY);
        add_row(ROW_QUERY, 0, MIN_V, 0, 0, 1, 0, pltbl_pkg::ST_EMPTY);

        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_COUNT: write_point_count(directed_rows[i].count);
                ROW_LOAD: send_item(pltbl_pkg::OP_LOAD, directed_rows[i].index,
                                    directed_rows[i].x, directed_rows[i].f, 1'b0, '0);
                default: send_item(pltbl_pkg::OP_QUERY, directed_rows[i].index,
                                   directed_rows[i].x, $urandom, directed_rows[i].typed,
                                   directed_rows[i].ans);
            endcase
        end

        // random phases: maybe load a breakpoint set, set the count, run queries
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase == 2)
            begin
                // full store, count above the depth
                count = (1 << pltbl_pkg::COUNT_W) - 1;
                reload = DEPTH;
            end
            else if (phase == 3)
            begin
                // same full store, count at the depth
                count = DEPTH;
                reload = 0;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 6)
                begin
                    count = 0;
                    reload = 0;
                end
                else if (r < 14 && phase > 3)
                begin
                    // stale store contents, count saturates
                    count = $urandom_range((1 << pltbl_pkg::COUNT_W) - 1, DEPTH + 1);
                    reload = 0;
                end
                else if (r < 24)
                begin
                    count = $urandom_range(96, 17);
                    reload = count;
                end
                else
                begin
                    count = $urandom_range(16, 1);
                    reload = count;
                end
            end
            if (reload > 0)
                load_breakpoints(reload, $urandom_range(99) < 20);
            write_point_count(pltbl_pkg::COUNT_W'(count));
            @(posedge clk);
            if (phase == 1)
                hold_left = HOLD_CYCLES;
            calm = (phase == 4);
            query_burst((phase == 2 || phase == 3) ? 40 : $urandom_range(60, 20));
            @(negedge clk);
            item_valid <= 1'b0;
            calm = 1'b0;
            phase++;
        end

        quiesce();
        $display("covered %0d loads and %0d queries over %0d point_count writes",
                 loads_sent, queries_sent, count_writes);
        $display("results: interior %0d, clamped low %0d, clamped high %0d, empty %0d",
                 status_seen[pltbl_pkg::ST_INTERIOR], status_seen[pltbl_pkg::ST_CLAMP_LOW],
                 status_seen[pltbl_pkg::ST_CLAMP_HIGH], status_seen[pltbl_pkg::ST_EMPTY]);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== piecewise_linear_table_interp_core.f =====
design/pltbl_pkg.sv
design/pltbl_dp.sv
design/pltbl_ctrl.sv
design/piecewise_linear_table_interp_core.sv
test/testbench.sv
